[rtl/hcb_pkg.sv]
// types and constants shared by the huffman code builder
package hcb_pkg;

  localparam int MAX_LEAVES_DEF = 64;
  localparam int SYM_W          = 8;
  localparam int WGT_W          = 24;
  localparam int NODE_WGT_W     = 30;
  localparam int CODE_W         = 63;
  localparam int LEN_W          = 6;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [WGT_W-1:0] weight;
    logic             last_leaf;
  } leaf_req_t;

  typedef struct packed {
    logic [SYM_W-1:0]  code_symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              last_code;
  } code_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE_L,
    ST_MERGE_R,
    ST_EM_START,
    ST_EM_PAR,
    ST_EM_STEP,
    ST_EM_OUT
  } state_e;

endpackage

[rtl/huffman_code_builder_unit.sv]
// Huffman code builder: loads weighted leaves, builds the tree with one
// shared min-two compare unit and emits one code per leaf in load order.
// A leaf request is taken when start is high and busy low. The request with
// last_leaf set starts the build once two or more leaves are held: merge k
// (k = 0..n-2) scans nodes 0..n+k-1 through the weight memory's single read
// port, one node a cycle, then writes the two parent links.
// Codes follow leaf by leaf: after a start and a parent-read state, the walk
// climbs to the root one tree level a cycle; an output state ends it.
// Each code is shown for one cycle with res_strobe_o high and
// cannot be held off; busy stays high from the last leaf until the final code.
module huffman_code_builder_unit #(
  parameter int MAX_LEAVES = hcb_pkg::MAX_LEAVES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  hcb_pkg::leaf_req_t req_i,
  output logic               res_strobe_o,
  output hcb_pkg::code_res_t res_o
);

  localparam int NODE_COUNT  = 2 * MAX_LEAVES - 1;
  localparam int INNER_COUNT = MAX_LEAVES - 1;
  localparam int NW  = $clog2(NODE_COUNT);
  localparam int CW  = $clog2(MAX_LEAVES + 1);
  localparam int LFW = $clog2(MAX_LEAVES);
  localparam int IW  = (INNER_COUNT > 1) ? $clog2(INNER_COUNT) : 1;
  localparam int WW  = hcb_pkg::NODE_WGT_W;
  localparam int SW  = hcb_pkg::SYM_W;
  localparam int BW  = hcb_pkg::CODE_W;
  localparam int LW  = hcb_pkg::LEN_W;

  hcb_pkg::state_e state_q, state_d;

  logic [CW-1:0]         leaf_cnt_q, leaf_cnt_d;
  logic [CW-1:0]         n_q, n_d;
  logic [NW-1:0]         i_q, i_d;
  logic [NW-1:0]         j_q, j_d;
  logic                  h1_q, h1_d, h2_q, h2_d;
  logic [NW-1:0]         s1_q, s1_d, s2_q, s2_d;
  logic [WW-1:0]         w1_q, w1_d, w2_q, w2_d;
  logic                  cand_vld_q, cand_vld_d;
  logic [NW-1:0]         cand_idx_q, cand_idx_d;
  logic [NODE_COUNT-1:0] pvalid_q, pvalid_d;
  logic [LFW-1:0]        leaf_q, leaf_d;
  logic [NW-1:0]         cur_q, cur_d;
  logic [NW-1:0]         f_q, f_d;
  logic [BW-1:0]         code_q, code_d;
  logic [LW-1:0]         len_q, len_d;

  // node and leaf stores
  logic [WW-1:0] wgt_mem  [NODE_COUNT];
  logic [NW-1:0] par_mem  [NODE_COUNT];
  logic [NW-1:0] left_mem [INNER_COUNT];
  logic [SW-1:0] sym_mem  [MAX_LEAVES];

  logic          wgt_we, par_we, left_we, sym_we;
  logic [NW-1:0] wgt_waddr, wgt_raddr, par_waddr, par_raddr;
  logic [WW-1:0] wgt_wdata;
  logic [NW-1:0] par_wdata, left_wdata;
  logic [IW-1:0] left_waddr, left_raddr;
  logic [LFW-1:0] sym_waddr;
  logic [SW-1:0] sym_wdata;

  logic [WW-1:0] wgt_rd_q;
  logic [NW-1:0] par_rd_q;
  logic          pval_rd_q;
  logic [NW-1:0] left_rd_q;
  logic [SW-1:0] sym_rd_q;

  logic          accept;
  logic          store;
  logic [CW-1:0] cnt_new;
  logic [NW:0]   i_last;
  logic [NW-1:0] f_cand;
  logic [LW-1:0] len_cmp;
  logic          walk_on;
  logic          last_code;

  assign busy   = (state_q != hcb_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign store  = (leaf_cnt_q < CW'(MAX_LEAVES));
  assign cnt_new = store ? leaf_cnt_q + CW'(1) : leaf_cnt_q;
  assign i_last = (NW+1)'({n_q, 1'b0}) - (NW+1)'(2);

  // walk step: parent of the node just reached, or none
  assign f_cand  = pval_rd_q ? par_rd_q : '0;
  assign len_cmp = (state_q == hcb_pkg::ST_EM_STEP) ? len_q + LW'(1) : len_q;
  assign walk_on = (f_cand != '0) && (f_cand >= NW'(n_q)) && (f_cand < NW'(NODE_COUNT))
                   && (len_cmp < LW'(BW));
  assign last_code = (leaf_q == LFW'(n_q - CW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hcb_pkg::ST_IDLE;
      leaf_cnt_q <= '0;
      n_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      h1_q       <= 1'b0;
      h2_q       <= 1'b0;
      cand_vld_q <= 1'b0;
      pvalid_q   <= '0;
      leaf_q     <= '0;
      cur_q      <= '0;
      f_q        <= '0;
      len_q      <= '0;
    end else begin
      state_q    <= state_d;
      leaf_cnt_q <= leaf_cnt_d;
      n_q        <= n_d;
      i_q        <= i_d;
      j_q        <= j_d;
      h1_q       <= h1_d;
      h2_q       <= h2_d;
      cand_vld_q <= cand_vld_d;
      pvalid_q   <= pvalid_d;
      leaf_q     <= leaf_d;
      cur_q      <= cur_d;
      f_q        <= f_d;
      len_q      <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q       <= s1_d;
    s2_q       <= s2_d;
    w1_q       <= w1_d;
    w2_q       <= w2_d;
    cand_idx_q <= cand_idx_d;
    code_q     <= code_d;
  end

  always_ff @(posedge clk_i) begin
    if (wgt_we) begin
      wgt_mem[wgt_waddr] <= wgt_wdata;
    end
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    if (left_we) begin
      left_mem[left_waddr] <= left_wdata;
    end
    if (sym_we) begin
      sym_mem[sym_waddr] <= sym_wdata;
    end
    wgt_rd_q  <= wgt_mem[wgt_raddr];
    par_rd_q  <= par_mem[par_raddr];
    pval_rd_q <= pvalid_q[par_raddr];
    left_rd_q <= left_mem[left_raddr];
    sym_rd_q  <= sym_mem[leaf_q];
  end

  // shared min-two compare unit, fed one scanned node per cycle
  always_comb begin
    h1_d = h1_q;
    h2_d = h2_q;
    s1_d = s1_q;
    s2_d = s2_q;
    w1_d = w1_q;
    w2_d = w2_q;
    if (cand_vld_q) begin
      if (!h1_q || (wgt_rd_q < w1_q)) begin
        w2_d = w1_q;
        s2_d = s1_q;
        h2_d = h1_q;
        w1_d = wgt_rd_q;
        s1_d = cand_idx_q;
        h1_d = 1'b1;
      end else if (!h2_q || (wgt_rd_q < w2_q)) begin
        w2_d = wgt_rd_q;
        s2_d = cand_idx_q;
        h2_d = 1'b1;
      end
    end
    // a new merge starts with an empty pick
    if (state_d == hcb_pkg::ST_SCAN && state_q != hcb_pkg::ST_SCAN) begin
      h1_d = 1'b0;
      h2_d = 1'b0;
    end
  end

  always_comb begin
    state_d    = state_q;
    leaf_cnt_d = leaf_cnt_q;
    n_d        = n_q;
    i_d        = i_q;
    j_d        = j_q;
    cand_vld_d = 1'b0;
    cand_idx_d = j_q;
    pvalid_d   = pvalid_q;
    leaf_d     = leaf_q;
    cur_d      = cur_q;
    f_d        = f_q;
    code_d     = code_q;
    len_d      = len_q;

    wgt_we     = 1'b0;
    wgt_waddr  = NW'(leaf_cnt_q);
    wgt_wdata  = WW'(req_i.weight);
    wgt_raddr  = j_q;
    par_we     = 1'b0;
    par_waddr  = s1_q;
    par_wdata  = i_q;
    par_raddr  = cur_q;
    left_we    = 1'b0;
    left_waddr = IW'(i_q - NW'(n_q));
    left_wdata = s1_q;
    left_raddr = IW'(f_q - NW'(n_q));
    sym_we     = 1'b0;
    sym_waddr  = LFW'(leaf_cnt_q);
    sym_wdata  = req_i.symbol;

    res_strobe_o = 1'b0;

    unique case (state_q)
      hcb_pkg::ST_IDLE: begin
        if (accept) begin
          // first leaf of a run drops all parent links
          if (leaf_cnt_q == '0) begin
            pvalid_d = '0;
          end
          if (store) begin
            wgt_we = 1'b1;
            sym_we = 1'b1;
          end
          leaf_cnt_d = cnt_new;
          if (req_i.last_leaf) begin
            leaf_cnt_d = '0;
            n_d        = cnt_new;
            leaf_d     = '0;
            if (cnt_new >= CW'(2)) begin
              i_d     = NW'(cnt_new);
              j_d     = '0;
              state_d = hcb_pkg::ST_SCAN;
            end else begin
              state_d = hcb_pkg::ST_EM_START;
            end
          end
        end
      end
      hcb_pkg::ST_SCAN: begin
        cand_vld_d = (j_q < i_q) && !pvalid_q[j_q];
        if (j_q == i_q) begin
          state_d = hcb_pkg::ST_MERGE_L;
        end else begin
          j_d = j_q + NW'(1);
        end
      end
      hcb_pkg::ST_MERGE_L: begin
        wgt_we    = 1'b1;
        wgt_waddr = i_q;
        wgt_wdata = w1_q + w2_q;
        par_we    = 1'b1;
        par_waddr = s1_q;
        pvalid_d[s1_q] = 1'b1;
        left_we   = 1'b1;
        state_d   = hcb_pkg::ST_MERGE_R;
      end
      hcb_pkg::ST_MERGE_R: begin
        par_we    = 1'b1;
        par_waddr = s2_q;
        pvalid_d[s2_q] = 1'b1;
        if ({1'b0, i_q} == i_last) begin
          state_d = hcb_pkg::ST_EM_START;
        end else begin
          i_d     = i_q + NW'(1);
          j_d     = '0;
          state_d = hcb_pkg::ST_SCAN;
        end
      end
      hcb_pkg::ST_EM_START: begin
        cur_d     = NW'(leaf_q);
        par_raddr = NW'(leaf_q);
        code_d    = '0;
        len_d     = '0;
        state_d   = hcb_pkg::ST_EM_PAR;
      end
      hcb_pkg::ST_EM_PAR, hcb_pkg::ST_EM_STEP: begin
        if (state_q == hcb_pkg::ST_EM_STEP) begin
          // right child contributes a one at this depth
          if (left_rd_q != cur_q) begin
            code_d[len_q] = 1'b1;
          end
          len_d = len_q + LW'(1);
          cur_d = f_q;
        end
        if (walk_on) begin
          f_d        = f_cand;
          par_raddr  = f_cand;
          left_raddr = IW'(f_cand - NW'(n_q));
          state_d    = hcb_pkg::ST_EM_STEP;
        end else begin
          state_d = hcb_pkg::ST_EM_OUT;
        end
      end
      hcb_pkg::ST_EM_OUT: begin
        res_strobe_o = 1'b1;
        if (last_code) begin
          state_d = hcb_pkg::ST_IDLE;
        end else begin
          leaf_d  = leaf_q + LFW'(1);
          state_d = hcb_pkg::ST_EM_START;
        end
      end
      default: begin
        state_d = hcb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.code_symbol = sym_rd_q;
    res_o.code_bits   = code_q;
    res_o.code_length = len_q;
    res_o.last_code   = last_code;
  end

endmodule

[sim/huffman_code_builder_unit_test.sv]
// self-checking testbench for the huffman code builder with a code scoreboard
class code_scoreboard;
  localparam int LEAF_MAX   = hcb_pkg::MAX_LEAVES_DEF;
  localparam int NODE_MAX   = 2 * hcb_pkg::MAX_LEAVES_DEF - 1;
  localparam int INNER_MAX  = hcb_pkg::MAX_LEAVES_DEF - 1;
  localparam int NODE_WGT_W = hcb_pkg::NODE_WGT_W;
  localparam int SYM_W      = hcb_pkg::SYM_W;
  localparam int CODE_W     = hcb_pkg::CODE_W;
  localparam int LEN_W      = hcb_pkg::LEN_W;

  logic [NODE_WGT_W-1:0] node_wgt [NODE_MAX];
  logic [6:0]            node_par [NODE_MAX];
  logic [6:0]            left_of  [INNER_MAX];
  logic [6:0]            right_of [INNER_MAX];
  logic [SYM_W-1:0]      sym_of   [LEAF_MAX];
  int unsigned           held;
  hcb_pkg::code_res_t    pending_codes [$];
  int                    errors;
  int                    codes_checked;
  int                    runs_built;
  int                    leaves_dropped;
  int                    deepest;

  function void build_tree(input int unsigned n);
    int unsigned s1, s2, w1, w2;
    bit          have1, have2;
    for (int unsigned i = n; i < 2 * n - 1; i++) begin
      s1 = 0; s2 = 0; w1 = 0; w2 = 0; have1 = 0; have2 = 0;
      for (int unsigned j = 0; j < i; j++) begin
        if (node_par[j] != 0) continue;
        if (!have1 || 32'(node_wgt[j]) < w1) begin
          w2 = w1; s2 = s1; have2 = have1;
          w1 = 32'(node_wgt[j]); s1 = j; have1 = 1;
        end else if (!have2 || 32'(node_wgt[j]) < w2) begin
          w2 = 32'(node_wgt[j]); s2 = j; have2 = 1;
        end
      end
      node_par[s1] = i[6:0];
      node_par[s2] = i[6:0];
      left_of[(i - n) % INNER_MAX]  = s1[6:0];
      right_of[(i - n) % INNER_MAX] = s2[6:0];
      node_wgt[i] = NODE_WGT_W'(w1 + w2);
    end
  endfunction

  function void note_leaf(input hcb_pkg::leaf_req_t r);
    int unsigned        n, c, f, len;
    logic [CODE_W-1:0]  bits;
    hcb_pkg::code_res_t res;
    if (held == 0) begin
      for (int j = 0; j < NODE_MAX; j++) node_par[j] = '0;
    end
    if (held < LEAF_MAX) begin
      sym_of[held]   = r.symbol;
      node_wgt[held] = NODE_WGT_W'(r.weight);
      held++;
    end else begin
      leaves_dropped++;
    end
    if (!r.last_leaf) return;
    n = held;
    if (n >= 2) build_tree(n);
    for (int unsigned i = 0; i < n; i++) begin
      bits = '0;
      len  = 0;
      c    = i;
      f    = (n >= 2) ? 32'(node_par[i]) : 0;
      // walk to the root, leaf-side bit lands lowest
      while (f != 0 && f >= n && f < NODE_MAX && len < CODE_W) begin
        if (32'(left_of[(f - n) % INNER_MAX]) != c) bits[len] = 1'b1;
        len++;
        c = f;
        f = 32'(node_par[f]);
      end
      if (len > deepest) deepest = len;
      res.code_symbol = sym_of[i];
      res.code_bits   = bits;
      res.code_length = len[LEN_W-1:0];
      res.last_code   = (i + 1 == n);
      pending_codes.push_back(res);
    end
    runs_built++;
    held = 0;
  endfunction

  function void check_code(input hcb_pkg::code_res_t got);
    hcb_pkg::code_res_t want;
    if (pending_codes.size() == 0) begin
      $display("%0t: unexpected code, expected none, actual sym %h bits %h len %0d last %b",
               $time, got.code_symbol, got.code_bits, got.code_length, got.last_code);
      errors++;
      return;
    end
    want = pending_codes.pop_front();
    codes_checked++;
    if (got.code_symbol !== want.code_symbol) begin
      $display("%0t: code_symbol expected %h actual %h", $time, want.code_symbol,
               got.code_symbol);
      errors++;
    end
    if (got.code_bits !== want.code_bits) begin
      $display("%0t: code_bits expected %h actual %h", $time, want.code_bits, got.code_bits);
      errors++;
    end
    if (got.code_length !== want.code_length) begin
      $display("%0t: code_length expected %0d actual %0d", $time, want.code_length,
               got.code_length);
      errors++;
    end
    if (got.last_code !== want.last_code) begin
      $display("%0t: last_code expected %b actual %b", $time, want.last_code, got.last_code);
      errors++;
    end
  endfunction

  function int pending();
    return pending_codes.size();
  endfunction
endclass

module huffman_code_builder_unit_test;
  localparam int ITEM_TARGET = 360;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 200;
  localparam int SYM_W       = hcb_pkg::SYM_W;
  localparam int WGT_W       = hcb_pkg::WGT_W;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start  = 1'b0;
  logic               busy;
  hcb_pkg::leaf_req_t req_i  = '0;
  logic               res_strobe_o;
  hcb_pkg::code_res_t res_o;

  code_scoreboard sb;
  int             items_sent;
  int             cycle_cnt = 0;
  bit             no_idle;

  huffman_code_builder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o === 1'b1) sb.check_code(res_o);
  end

  task automatic send_leaf(input logic [SYM_W-1:0] sym, input logic [WGT_W-1:0] wgt,
                           input logic last);
    int                 gap;
    hcb_pkg::leaf_req_t r;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    r.symbol    = sym;
    r.weight    = wgt;
    r.last_leaf = last;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_leaf(r);
    items_sent++;
  endtask

  // hold requests off until every pending code is out
  task automatic drain_codes();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic random_run(input int leaves);
    int                 wmode;
    logic [WGT_W-1:0]   wgt;
    wmode = $urandom_range(0, 3);
    for (int k = 0; k < leaves; k++) begin
      case (wmode)
        0: wgt = WGT_W'($urandom_range(0, 24'hFFFFFF));
        1: wgt = WGT_W'($urandom_range(0, 3));            // heavy ties and zeros
        2: wgt = 24'd1 << $urandom_range(0, WGT_W - 1);
        default: wgt = 24'd1 << ((k > WGT_W - 1) ? WGT_W - 1 : k);  // deep trees
      endcase
      send_leaf(SYM_W'($urandom_range(0, 255)), wgt, k == leaves - 1);
    end
  endtask

  initial begin
    int kind;
    int leaves;
    int run_idx;
    sb = new;
    items_sent = 0;
    no_idle    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single leaf gets an empty code
    send_leaf(8'h00, 24'd1, 1'b1);
    send_leaf(8'hFF, 24'hFFFFFF, 1'b1);
    // extreme weights, zero weight included
    send_leaf(8'hFF, 24'hFFFFFF, 1'b0);
    send_leaf(8'h00, 24'd0, 1'b1);
    // equal weights, lowest index wins the tie
    no_idle = 1'b1;
    send_leaf(8'h11, 24'd5, 1'b0);
    send_leaf(8'h22, 24'd5, 1'b0);
    send_leaf(8'h33, 24'd5, 1'b0);
    send_leaf(8'h44, 24'd5, 1'b1);
    no_idle = 1'b0;
    send_leaf(8'hA5, 24'd0, 1'b0);
    send_leaf(8'h5A, 24'd0, 1'b0);
    send_leaf(8'h3C, 24'd7, 1'b1);
    drain_codes();

    run_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (run_idx == 0) leaves = 64;
      else if (run_idx == 1) leaves = 67;                  // leaves past the limit are dropped
      else if (kind < 75) leaves = $urandom_range(1, 8);
      else if (kind < 90) leaves = $urandom_range(9, 24);
      else if (kind < 95) leaves = 64;
      else leaves = $urandom_range(65, 68);
      random_run(leaves);
      if (run_idx == 2 || $urandom_range(0, 9) == 0) drain_codes();
      run_idx++;
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d leaf requests in %0d builds, %0d leaves dropped past the limit",
             items_sent, sb.runs_built, sb.leaves_dropped);
    $display("checked %0d codes, deepest code %0d bits", sb.codes_checked, sb.deepest);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
